>>> sv/fscu_pkg.sv
// ----------------------------------------------------------------------------
// fscu_pkg
// Shared types, cell and operation codes, and command/status bundles for the
// falling sand cell update block.
// ----------------------------------------------------------------------------
package fscu_pkg;

    typedef logic [2:0] cell_t;
    typedef logic [1:0] func_t;
    typedef logic [2:0] dir_t;
    typedef logic [2:0] wsrc_t;
    typedef logic [0:0] reg_idx_t;
    typedef logic [6:0] pct_t;

    // cell codes
    localparam cell_t CELL_EMPTY = 3'd0;
    localparam cell_t CELL_SAND  = 3'd1;
    localparam cell_t CELL_WALL  = 3'd2;
    localparam cell_t CELL_WATER = 3'd3;
    localparam cell_t CELL_FIXED = 3'd4;
    localparam cell_t CELL_OIL   = 3'd5;
    localparam cell_t CELL_FIRE  = 3'd6;
    localparam cell_t CELL_NONE  = 3'd7;

    // operation codes (code three acts as read)
    localparam func_t FUNC_UPDATE = 2'd0;
    localparam func_t FUNC_PAINT  = 2'd1;
    localparam func_t FUNC_READ   = 2'd2;

    // neighbor directions; DIR_NONE addresses the visited cell itself
    localparam dir_t DIR_NONE  = 3'd0;
    localparam dir_t DIR_DOWN  = 3'd1;
    localparam dir_t DIR_LEFT  = 3'd2;
    localparam dir_t DIR_RIGHT = 3'd3;
    localparam dir_t DIR_DL    = 3'd4;
    localparam dir_t DIR_DR    = 3'd5;
    localparam dir_t DIR_UP    = 3'd6;

    // grid write data sources
    localparam wsrc_t WSRC_EMPTY = 3'd0;
    localparam wsrc_t WSRC_PAINT = 3'd1;
    localparam wsrc_t WSRC_MEMQ  = 3'd2;
    localparam wsrc_t WSRC_CUR   = 3'd3;
    localparam wsrc_t WSRC_FIRE  = 3'd4;

    // configuration register indexes
    localparam reg_idx_t REG_EXTINGUISH_PCT = 1'b0;
    localparam reg_idx_t REG_IGNITE_PCT     = 1'b1;

    localparam pct_t EXTINGUISH_PCT_RST = 7'd20;
    localparam pct_t IGNITE_PCT_RST     = 7'd50;

    typedef struct packed {
        logic  load;
        logic  clr;
        logic  mem_rd;
        logic  mem_wr;
        logic  addr_self;
        dir_t  dir;
        wsrc_t wsrc;
        logic  take_cur;
        logic  set_paint;
        logic  set_move;
        logic  set_ext;
        logic  set_ign;
        logic  out_load;
    } fscu_cmd_t;

    typedef struct packed {
        func_t func;
        cell_t rd_cell;
        cell_t cur;
        logic  self_in_grid;
        logic  nb_in_grid;
        logic  probe_hit;
        logic  ign_hit;
        logic  ext_hit;
        logic  paint_ok;
        logic  clr_last;
        logic  out_free;
    } fscu_status_t;

    // move order: sand tries down, down-left, down-right; fluids add sideways
    function automatic dir_t probe_dir(input logic sand, input logic [2:0] step);
        dir_t d;
        d = DIR_DR;
        if (sand) begin
            case (step)
                3'd0:    d = DIR_DOWN;
                3'd1:    d = DIR_DL;
                default: d = DIR_DR;
            endcase
        end else begin
            case (step)
                3'd0:    d = DIR_DOWN;
                3'd1:    d = DIR_LEFT;
                3'd2:    d = DIR_RIGHT;
                3'd3:    d = DIR_DL;
                default: d = DIR_DR;
            endcase
        end
        return d;
    endfunction

    function automatic logic probe_last(input logic sand, input logic [2:0] step);
        return sand ? (step == 3'd2) : (step == 3'd4);
    endfunction

    function automatic dir_t ign_dir(input logic [2:0] step);
        dir_t d;
        case (step)
            3'd0:    d = DIR_DOWN;
            3'd1:    d = DIR_LEFT;
            3'd2:    d = DIR_RIGHT;
            default: d = DIR_UP;
        endcase
        return d;
    endfunction

    function automatic logic [3:0] ign_bit(input dir_t d);
        logic [3:0] b;
        case (d)
            DIR_DOWN:  b = 4'b0001;
            DIR_LEFT:  b = 4'b0010;
            DIR_RIGHT: b = 4'b0100;
            DIR_UP:    b = 4'b1000;
            default:   b = 4'b0000;
        endcase
        return b;
    endfunction

endpackage

>>> sv/fscu_ctrl.sv
// ----------------------------------------------------------------------------
// fscu_ctrl
// Controller: sequences the reset clearing sweep and, per item, the grid
// reads and writes of update, paint and read operations.
// ----------------------------------------------------------------------------
module fscu_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  fscu_pkg::fscu_status_t status,
    output fscu_pkg::fscu_cmd_t    cmd
);

    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_RD_SELF   = 4'd2;
    localparam logic [3:0] ST_EVAL      = 4'd3;
    localparam logic [3:0] ST_WR_PAINT  = 4'd4;
    localparam logic [3:0] ST_PROBE     = 4'd5;
    localparam logic [3:0] ST_PROBE_CHK = 4'd6;
    localparam logic [3:0] ST_WR_NB     = 4'd7;
    localparam logic [3:0] ST_FIRE_EXT  = 4'd8;
    localparam logic [3:0] ST_IGN_RD    = 4'd9;
    localparam logic [3:0] ST_IGN_CHK   = 4'd10;
    localparam logic [3:0] ST_FIN       = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       sand;
    logic       plast;
    logic       ilast;

    assign sand  = (status.cur == fscu_pkg::CELL_SAND);
    assign plast = fscu_pkg::probe_last(sand, step_reg);
    assign ilast = (step_reg == 3'd3);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr    = 1'b1;
                cmd.mem_wr = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD_SELF;
                end
            end
            ST_RD_SELF: begin
                cmd.addr_self = 1'b1;
                if (status.self_in_grid) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_EVAL;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_EVAL: begin
                cmd.take_cur = 1'b1;
                step_next    = 3'd0;
                state_next   = ST_FIN;
                case (status.func)
                    fscu_pkg::FUNC_UPDATE: begin
                        if (status.rd_cell == fscu_pkg::CELL_SAND ||
                            status.rd_cell == fscu_pkg::CELL_WATER ||
                            status.rd_cell == fscu_pkg::CELL_OIL) begin
                            state_next = ST_PROBE;
                        end else if (status.rd_cell == fscu_pkg::CELL_FIRE) begin
                            state_next = ST_FIRE_EXT;
                        end
                    end
                    fscu_pkg::FUNC_PAINT: begin
                        if (status.paint_ok && status.rd_cell != fscu_pkg::CELL_FIXED) begin
                            state_next = ST_WR_PAINT;
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_WR_PAINT: begin
                cmd.addr_self = 1'b1;
                cmd.mem_wr    = 1'b1;
                cmd.wsrc      = fscu_pkg::WSRC_PAINT;
                cmd.set_paint = 1'b1;
                state_next    = ST_FIN;
            end
            ST_PROBE: begin
                cmd.dir = fscu_pkg::probe_dir(sand, step_reg);
                if (status.nb_in_grid) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_PROBE_CHK;
                end else if (plast) begin
                    state_next = ST_FIN;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_PROBE_CHK: begin
                cmd.dir = fscu_pkg::probe_dir(sand, step_reg);
                if (status.probe_hit) begin
                    // self takes the neighbor's content, neighbor gets ours next
                    cmd.addr_self = 1'b1;
                    cmd.mem_wr    = 1'b1;
                    cmd.wsrc      = fscu_pkg::WSRC_MEMQ;
                    cmd.set_move  = 1'b1;
                    state_next    = ST_WR_NB;
                end else if (plast) begin
                    state_next = ST_FIN;
                end else begin
                    step_next  = step_reg + 3'd1;
                    state_next = ST_PROBE;
                end
            end
            ST_WR_NB: begin
                cmd.dir    = fscu_pkg::probe_dir(sand, step_reg);
                cmd.mem_wr = 1'b1;
                cmd.wsrc   = fscu_pkg::WSRC_CUR;
                state_next = ST_FIN;
            end
            ST_FIRE_EXT: begin
                cmd.addr_self = 1'b1;
                step_next     = 3'd0;
                state_next    = ST_IGN_RD;
                if (status.ext_hit) begin
                    cmd.mem_wr  = 1'b1;
                    cmd.wsrc    = fscu_pkg::WSRC_EMPTY;
                    cmd.set_ext = 1'b1;
                end
            end
            ST_IGN_RD: begin
                cmd.dir = fscu_pkg::ign_dir(step_reg);
                if (status.nb_in_grid) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_IGN_CHK;
                end else if (ilast) begin
                    state_next = ST_FIN;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_IGN_CHK: begin
                cmd.dir = fscu_pkg::ign_dir(step_reg);
                if (status.ign_hit) begin
                    cmd.mem_wr  = 1'b1;
                    cmd.wsrc    = fscu_pkg::WSRC_FIRE;
                    cmd.set_ign = 1'b1;
                end
                if (ilast) begin
                    state_next = ST_FIN;
                end else begin
                    step_next  = step_reg + 3'd1;
                    state_next = ST_IGN_RD;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            step_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

>>> sv/fscu_dp.sv
// ----------------------------------------------------------------------------
// fscu_dp
// Datapath: grid memory with registered read, item and config registers,
// neighbor addressing, rule compares, result accumulation and output register.
// ----------------------------------------------------------------------------
module fscu_dp #(
    parameter int GRID_WIDTH  = 512,
    parameter int GRID_HEIGHT = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fscu_pkg::fscu_cmd_t    cmd,
    output fscu_pkg::fscu_status_t status,
    input  logic [55:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    input  logic                  cfg_wr_en,
    input  fscu_pkg::reg_idx_t     cfg_addr,
    input  logic [6:0]            cfg_wdata
);

    localparam int CAW    = $clog2(GRID_WIDTH);
    localparam int RAW    = $clog2(GRID_HEIGHT);
    localparam int AW     = CAW + RAW;
    localparam int DEPTH  = 1 << AW;
    // coordinate widths leave room for +1 and make -1 from zero land outside
    localparam int COL_CW = (CAW + 1 > 10) ? CAW + 1 : 10;
    localparam int ROW_CW = (RAW + 1 > 10) ? RAW + 1 : 10;
    localparam logic [COL_CW-1:0] COL_LIM  = COL_CW'(GRID_WIDTH);
    localparam logic [ROW_CW-1:0] ROW_LIM  = ROW_CW'(GRID_HEIGHT);
    localparam logic [CAW-1:0]    COL_LAST = CAW'(GRID_WIDTH - 1);
    localparam logic [RAW-1:0]    ROW_LAST = RAW'(GRID_HEIGHT - 1);

    fscu_pkg::cell_t grid_mem [DEPTH];
    fscu_pkg::cell_t mem_q_reg;

    fscu_pkg::func_t func_reg;
    logic [8:0]      col_reg;
    logic [8:0]      row_reg;
    fscu_pkg::cell_t paint_reg;
    fscu_pkg::pct_t  ext_roll_reg;
    fscu_pkg::pct_t  roll_below_reg;
    fscu_pkg::pct_t  roll_left_reg;
    fscu_pkg::pct_t  roll_right_reg;
    fscu_pkg::pct_t  roll_above_reg;
    fscu_pkg::pct_t  ext_pct_reg;
    fscu_pkg::pct_t  ign_pct_reg;

    fscu_pkg::cell_t cur_reg;
    fscu_pkg::cell_t type_reg;
    fscu_pkg::dir_t  move_reg;
    logic [3:0]      mask_reg;
    logic            ext_reg;

    fscu_pkg::cell_t out_type_reg;
    fscu_pkg::dir_t  out_move_reg;
    logic [3:0]      out_mask_reg;
    logic            out_ext_reg;
    logic            m_tvalid_reg, m_tvalid_next;

    logic [AW-1:0]   clr_cnt_reg;

    logic [COL_CW-1:0] col_ext, nb_col;
    logic [ROW_CW-1:0] row_ext, nb_row;
    logic [AW-1:0]     mem_addr;
    fscu_pkg::cell_t   mem_wdata;
    fscu_pkg::cell_t   clr_val;
    fscu_pkg::pct_t    ign_roll;
    logic              self_in_grid;

    assign col_ext = COL_CW'(col_reg);
    assign row_ext = ROW_CW'(row_reg);

    always_comb begin
        nb_col = col_ext;
        nb_row = row_ext;
        case (cmd.dir)
            fscu_pkg::DIR_DOWN: begin
                nb_row = row_ext + ROW_CW'(1);
            end
            fscu_pkg::DIR_LEFT: begin
                nb_col = col_ext - COL_CW'(1);
            end
            fscu_pkg::DIR_RIGHT: begin
                nb_col = col_ext + COL_CW'(1);
            end
            fscu_pkg::DIR_DL: begin
                nb_col = col_ext - COL_CW'(1);
                nb_row = row_ext + ROW_CW'(1);
            end
            fscu_pkg::DIR_DR: begin
                nb_col = col_ext + COL_CW'(1);
                nb_row = row_ext + ROW_CW'(1);
            end
            fscu_pkg::DIR_UP: begin
                nb_row = row_ext - ROW_CW'(1);
            end
            default: begin
                nb_col = col_ext;
                nb_row = row_ext;
            end
        endcase
    end

    assign self_in_grid = (col_ext < COL_LIM) && (row_ext < ROW_LIM);

    always_comb begin
        if (cmd.clr) begin
            mem_addr = clr_cnt_reg;
        end else if (cmd.addr_self) begin
            mem_addr = {row_ext[RAW-1:0], col_ext[CAW-1:0]};
        end else begin
            mem_addr = {nb_row[RAW-1:0], nb_col[CAW-1:0]};
        end
    end

    // reset image: fixed walls on the border, empty inside
    assign clr_val = (clr_cnt_reg[AW-1:CAW] == '0 || clr_cnt_reg[AW-1:CAW] == ROW_LAST ||
                      clr_cnt_reg[CAW-1:0] == '0 || clr_cnt_reg[CAW-1:0] == COL_LAST)
                     ? fscu_pkg::CELL_FIXED : fscu_pkg::CELL_EMPTY;

    always_comb begin
        if (cmd.clr) begin
            mem_wdata = clr_val;
        end else begin
            case (cmd.wsrc)
                fscu_pkg::WSRC_PAINT: mem_wdata = paint_reg;
                fscu_pkg::WSRC_MEMQ:  mem_wdata = mem_q_reg;
                fscu_pkg::WSRC_CUR:   mem_wdata = cur_reg;
                fscu_pkg::WSRC_FIRE:  mem_wdata = fscu_pkg::CELL_FIRE;
                default:              mem_wdata = fscu_pkg::CELL_EMPTY;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            grid_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            mem_q_reg <= grid_mem[mem_addr];
        end
    end

    always_comb begin
        case (cmd.dir)
            fscu_pkg::DIR_DOWN:  ign_roll = roll_below_reg;
            fscu_pkg::DIR_LEFT:  ign_roll = roll_left_reg;
            fscu_pkg::DIR_RIGHT: ign_roll = roll_right_reg;
            default:             ign_roll = roll_above_reg;
        endcase
    end

    assign status.func         = func_reg;
    assign status.rd_cell      = mem_q_reg;
    assign status.cur          = cur_reg;
    assign status.self_in_grid = self_in_grid;
    assign status.nb_in_grid   = (nb_col < COL_LIM) && (nb_row < ROW_LIM);
    assign status.probe_hit    = (mem_q_reg == fscu_pkg::CELL_EMPTY) ||
                                 (mem_q_reg == fscu_pkg::CELL_WATER &&
                                  cur_reg != fscu_pkg::CELL_WATER);
    assign status.ign_hit      = (mem_q_reg == fscu_pkg::CELL_OIL) && (ign_roll < ign_pct_reg);
    assign status.ext_hit      = (ext_roll_reg < ext_pct_reg);
    assign status.paint_ok     = (paint_reg != fscu_pkg::CELL_NONE);
    assign status.clr_last     = &clr_cnt_reg;
    assign status.out_free     = !m_tvalid_reg || m_tready;

    // item and per-item accumulators
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg       <= s_tuser;
            col_reg        <= s_tdata[8:0];
            row_reg        <= s_tdata[17:9];
            paint_reg      <= s_tdata[20:18];
            ext_roll_reg   <= s_tdata[27:21];
            roll_below_reg <= s_tdata[34:28];
            roll_left_reg  <= s_tdata[41:35];
            roll_right_reg <= s_tdata[48:42];
            roll_above_reg <= s_tdata[55:49];
            type_reg       <= fscu_pkg::CELL_EMPTY;
            move_reg       <= fscu_pkg::DIR_NONE;
            mask_reg       <= 4'b0000;
            ext_reg        <= 1'b0;
        end else begin
            if (cmd.take_cur) begin
                cur_reg  <= mem_q_reg;
                type_reg <= mem_q_reg;
            end
            if (cmd.set_paint) begin
                type_reg <= paint_reg;
            end
            if (cmd.set_move) begin
                type_reg <= mem_q_reg;
                move_reg <= cmd.dir;
            end
            if (cmd.set_ext) begin
                type_reg <= fscu_pkg::CELL_EMPTY;
                ext_reg  <= 1'b1;
            end
            if (cmd.set_ign) begin
                mask_reg <= mask_reg | fscu_pkg::ign_bit(cmd.dir);
            end
        end
        if (cmd.out_load) begin
            out_type_reg <= type_reg;
            out_move_reg <= move_reg;
            out_mask_reg <= mask_reg;
            out_ext_reg  <= ext_reg;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            clr_cnt_reg  <= '0;
            ext_pct_reg  <= fscu_pkg::EXTINGUISH_PCT_RST;
            ign_pct_reg  <= fscu_pkg::IGNITE_PCT_RST;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.clr) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    fscu_pkg::REG_EXTINGUISH_PCT: ext_pct_reg <= cfg_wdata;
                    fscu_pkg::REG_IGNITE_PCT:     ign_pct_reg <= cfg_wdata;
                    default:                      ext_pct_reg <= ext_pct_reg;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, out_ext_reg, out_mask_reg, out_move_reg, out_type_reg};

endmodule

>>> sv/falling_sand_cell_update.sv
// ----------------------------------------------------------------------------
// falling_sand_cell_update
// Falling sand grid engine: update, paint or read one grid cell per transfer.
//
//   channel   ports                      payload (lowest bit up)
//   input     s_tvalid/s_tready/s_tdata  tdata: col, row, paint_type,
//             s_tuser                      extinguish_roll, roll_below,
//                                          roll_left, roll_right, roll_above
//                                        tuser: func
//   result    m_tvalid/m_tready/m_tdata  cell_type, move_dir, ignite_mask,
//                                          extinguished, zero pad
//   config    cfg_wr_en/cfg_addr/        0 extinguish_percent,
//             cfg_wdata                    1 ignite_percent
//
// One item at a time over the single grid memory port, one access a cycle.
// Per item: a read of the cell itself; for paint, a write of it; for sand,
// water and oil, a read per probed neighbor until one is free, then two swap
// writes; for fire, a possible clear, then neighbor reads and ignite writes.
// After reset the grid is swept once, one entry a cycle, over all
// 2**(clog2(GRID_WIDTH)+clog2(GRID_HEIGHT)) entries before s_tready rises.
// A result waiting on m_tready does not block the next input transfer; the
// item after it stalls only at its own finish.
// ----------------------------------------------------------------------------
module falling_sand_cell_update #(
    parameter int GRID_WIDTH  = 512,
    parameter int GRID_HEIGHT = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // col, row, paint_type, extinguish_roll,
                                   // roll_below, roll_left, roll_right, roll_above
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // cell_type, move_dir, ignite_mask, extinguished
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata
);

    fscu_pkg::fscu_cmd_t    cmd;
    fscu_pkg::fscu_status_t status;

    fscu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fscu_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

>>> sv/fscu_chk.sv
// ----------------------------------------------------------------------------
// fscu_chk
// Port checker for the falling sand cell update block, bound to the top level.
// ----------------------------------------------------------------------------
module fscu_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no transfer right after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken back to back");

    a_move_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:3] != 3'd6) && (m_tdata[5:3] != 3'd7))
        else $error("move code out of range");

    // an extinguished fire leaves an empty cell and never moves
    a_ext_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> (m_tdata[2:0] == 3'd0) && (m_tdata[5:3] == 3'd0))
        else $error("extinguished cell not empty");

    a_ign_nomove: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[9:6] != 4'd0) |-> (m_tdata[5:3] == 3'd0))
        else $error("ignition reported with a move");

endmodule

bind falling_sand_cell_update fscu_chk u_fscu_chk (.*);
